// File: sv/max_flow_edmonds_karp_defines.svh
// ----------------------------------------------------------------------------
// Max flow assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_EDMONDS_KARP_DEFINES_SVH
`define MAX_FLOW_EDMONDS_KARP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MFEK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mfek assertion failed");
`define MFEK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mfek assertion failed");
`else
`define MFEK_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MFEK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/mfek_pkg.sv
// ----------------------------------------------------------------------------
// Max flow package
// Request codes, constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package mfek_pkg;

	localparam int VALUE_W       = 23;
	localparam int VALUE_POS_MAX = 4194303;
	localparam int VC_W          = 7;
	localparam logic [6:0] VC_RESET = 7'd64;

	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_SET     = 2'd1,
		REQ_COMPUTE = 2'd2,
		REQ_QUERY   = 2'd3
	} req_t;

	typedef struct packed {
		logic accept;
		logic clr_cap;
		logic clr_flow;
		logic cap_write;
		logic q_rd;
		logic bfs_init;
		logic pop_rd;
		logic pop_take;
		logic scan_rd;
		logic scan_chk;
		logic found;
		logic prd;
		logic w1_q;
		logic w1_min;
		logic w2_start;
		logic w2_q;
		logic w2_fwd;
		logic w2_bwd;
		logic add_total;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		req_t kind;
		logic same_ab;
		logic range_ok;
		logic clr_done;
		logic pop_more;
		logic scan_last;
		logic snk_found;
		logic p_is_src;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: sv/mfek_ctrl.sv
// ----------------------------------------------------------------------------
// Max flow controller
// Sequences sweeps, breadth-first search and path augmentation.
// ----------------------------------------------------------------------------
`default_nettype none

module mfek_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  mfek_pkg::sts_t     sts,
	output mfek_pkg::cmd_t     cmd
);

	typedef enum logic [20:0] {
		S_IDLE     = 21'h000001,
		S_CLR_ALL  = 21'h000002,
		S_CLR_CAP  = 21'h000004,
		S_CLR_FLOW = 21'h000008,
		S_DISP     = 21'h000010,
		S_SET      = 21'h000020,
		S_QRD      = 21'h000040,
		S_BFS_INIT = 21'h000080,
		S_POP      = 21'h000100,
		S_POPW     = 21'h000200,
		S_SRD      = 21'h000400,
		S_SCHK     = 21'h000800,
		S_FOUND    = 21'h001000,
		S_W1P      = 21'h002000,
		S_W1Q      = 21'h004000,
		S_W1R      = 21'h008000,
		S_W2P      = 21'h010000,
		S_W2Q      = 21'h020000,
		S_W2A      = 21'h040000,
		S_W2B      = 21'h080000,
		S_RESP     = 21'h100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_ALL;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISP;
				end
			end
			S_CLR_ALL: begin
				cmd.clr_cap  = 1'b1;
				cmd.clr_flow = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_CLR_CAP: begin
				cmd.clr_cap = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_CLR_FLOW: begin
				cmd.clr_flow = 1'b1;
				if (sts.clr_done) state_d = sts.range_ok ? S_BFS_INIT : S_RESP;
			end
			S_DISP: begin
				unique case (sts.kind)
					mfek_pkg::REQ_CLEAR:   state_d = S_CLR_CAP;
					mfek_pkg::REQ_SET:     state_d = S_SET;
					mfek_pkg::REQ_COMPUTE: state_d = sts.same_ab ? S_RESP : S_CLR_FLOW;
					mfek_pkg::REQ_QUERY:   state_d = S_QRD;
					default:               state_d = S_IDLE;
				endcase
			end
			S_SET: begin
				cmd.cap_write = 1'b1;
				state_d       = S_IDLE;
			end
			S_QRD: begin
				cmd.q_rd = 1'b1;
				state_d  = S_RESP;
			end
			S_BFS_INIT: begin
				cmd.bfs_init = 1'b1;
				state_d      = S_POP;
			end
			S_POP: begin
				if (sts.pop_more) begin
					cmd.pop_rd = 1'b1;
					state_d    = S_POPW;
				end else begin
					state_d = S_FOUND;
				end
			end
			S_POPW: begin
				cmd.pop_take = 1'b1;
				state_d      = S_SRD;
			end
			S_SRD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCHK;
			end
			S_SCHK: begin
				cmd.scan_chk = 1'b1;
				state_d      = sts.scan_last ? S_POP : S_SRD;
			end
			S_FOUND: begin
				if (sts.snk_found) begin
					cmd.found = 1'b1;
					state_d   = S_W1P;
				end else begin
					state_d = S_RESP;
				end
			end
			S_W1P: begin
				if (sts.p_is_src) begin
					cmd.w2_start = 1'b1;
					state_d      = S_W2P;
				end else begin
					cmd.prd = 1'b1;
					state_d = S_W1Q;
				end
			end
			S_W1Q: begin
				cmd.w1_q = 1'b1;
				state_d  = S_W1R;
			end
			S_W1R: begin
				cmd.w1_min = 1'b1;
				state_d    = S_W1P;
			end
			S_W2P: begin
				if (sts.p_is_src) begin
					cmd.add_total = 1'b1;
					state_d       = S_BFS_INIT;
				end else begin
					cmd.prd = 1'b1;
					state_d = S_W2Q;
				end
			end
			S_W2Q: begin
				cmd.w2_q = 1'b1;
				state_d  = S_W2A;
			end
			S_W2A: begin
				cmd.w2_fwd = 1'b1;
				state_d    = S_W2B;
			end
			S_W2B: begin
				cmd.w2_bwd = 1'b1;
				state_d    = S_W2P;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: sv/mfek_dp.sv
// ----------------------------------------------------------------------------
// Max flow datapath
// Capacity, flow, parent and queue memories, search counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "max_flow_edmonds_karp_defines.svh"

module mfek_dp #(
	parameter int MAX_VERTICES   = 64,
	parameter int CAPACITY_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [6:0]         vertex_count,
	input  wire logic [1:0]         req_type,
	input  wire logic [5:0]         vertex_a,
	input  wire logic [5:0]         vertex_b,
	input  wire logic [15:0]        edge_capacity,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic signed [22:0]      value,
	output logic                    bad_request,
	input  mfek_pkg::cmd_t          cmd,
	output mfek_pkg::sts_t          sts
);

	localparam int VW     = $clog2(MAX_VERTICES);
	localparam int AW     = 2 * VW;
	localparam int MDEPTH = 1 << AW;
	localparam int VDEPTH = 1 << VW;
	localparam int NW     = $clog2(MAX_VERTICES + 1);
	localparam int CW     = CAPACITY_WIDTH;
	localparam int FW     = CW + 1;
	localparam int RW     = CW + 2;
	localparam int TW     = CW + VW;
	localparam int EW     = CW + 16;
	localparam int SW     = TW + 23;

	logic [CW-1:0]        cap_mem  [0:MDEPTH-1];
	logic signed [FW-1:0] flow_mem [0:MDEPTH-1];
	logic [VW-1:0]        par_mem  [0:VDEPTH-1];
	logic [VW-1:0]        que_mem  [0:VDEPTH-1];

	logic [CW-1:0]        cap_rd_q;
	logic signed [FW-1:0] flow_rd_q;
	logic [VW-1:0]        par_rd_q;
	logic [VW-1:0]        que_rd_q;

	logic [6:0]            vc_q;
	mfek_pkg::req_t        req_q;
	logic [5:0]            a_q, b_q;
	logic [15:0]           ec_q;
	logic [AW-1:0]         clr_q;
	logic [NW-1:0]         head_q, tail_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [VW-1:0]         here_q, there_q, p_q, q_q;
	logic [CW-1:0]         amount_q;
	logic [TW-1:0]         total_q;
	logic                  out_valid_q;
	logic signed [22:0]    value_q;
	logic                  bad_q;

	logic [NW-1:0]         n_act;
	logic [VW-1:0]         src_v, snk_v;
	logic                  range_ok;
	logic [EW-1:0]         ec_ext;
	logic [CW-1:0]         cap_wr;
	logic signed [RW-1:0]  resid;
	logic                  resid_pos;
	logic                  hit;
	logic                  out_free;
	logic [FW+22:0]        flow_ext;
	logic [22:0]           total_sat;
	logic signed [22:0]    value_d;

	logic                  cap_we, cap_re, flow_we, flow_re, par_we, que_we;
	logic [AW-1:0]         cap_wa, cap_ra, flow_wa, flow_ra;
	logic [CW-1:0]         cap_wd;
	logic signed [FW-1:0]  flow_wd;
	logic [VW-1:0]         par_wa, par_wd, que_wa, que_wd;

	assign src_v    = VW'(a_q);
	assign snk_v    = VW'(b_q);
	assign range_ok = (32'(a_q) < 32'(MAX_VERTICES)) && (32'(b_q) < 32'(MAX_VERTICES));

	always_comb begin
		if (vc_q == '0) begin
			n_act = NW'(1);
		end else if (32'(vc_q) > 32'(MAX_VERTICES)) begin
			n_act = NW'(MAX_VERTICES);
		end else begin
			n_act = NW'(vc_q);
		end
	end

	assign ec_ext = EW'(ec_q);
	assign cap_wr = (ec_ext > EW'({CW{1'b1}})) ? {CW{1'b1}} : CW'(ec_q);

	assign resid     = $signed({2'b00, cap_rd_q}) - $signed({flow_rd_q[FW-1], flow_rd_q});
	assign resid_pos = !resid[RW-1] && (resid != '0);
	assign hit       = cmd.scan_chk && !visited_q[there_q] && resid_pos
		&& (tail_q < NW'(MAX_VERTICES));

	// memory port selection
	assign cap_we  = cmd.clr_cap || (cmd.cap_write && range_ok);
	assign cap_wa  = cmd.clr_cap ? clr_q : {VW'(a_q), VW'(b_q)};
	assign cap_wd  = cmd.clr_cap ? '0 : cap_wr;
	assign cap_re  = cmd.scan_rd || cmd.w1_q;
	assign cap_ra  = cmd.scan_rd ? {here_q, there_q} : {par_rd_q, p_q};

	assign flow_we = cmd.clr_flow || cmd.w2_fwd || cmd.w2_bwd;
	always_comb begin
		if (cmd.clr_flow) begin
			flow_wa = clr_q;
			flow_wd = '0;
		end else if (cmd.w2_fwd) begin
			flow_wa = {q_q, p_q};
			flow_wd = flow_rd_q + $signed({1'b0, amount_q});
		end else begin
			flow_wa = {p_q, q_q};
			flow_wd = flow_rd_q - $signed({1'b0, amount_q});
		end
	end
	assign flow_re = cmd.q_rd || cmd.scan_rd || cmd.w1_q || cmd.w2_q || cmd.w2_fwd;
	always_comb begin
		if (cmd.q_rd) begin
			flow_ra = {VW'(a_q), VW'(b_q)};
		end else if (cmd.scan_rd) begin
			flow_ra = {here_q, there_q};
		end else if (cmd.w2_fwd) begin
			flow_ra = {p_q, q_q};
		end else begin
			flow_ra = {par_rd_q, p_q};
		end
	end

	assign par_we = cmd.bfs_init || hit;
	assign par_wa = cmd.bfs_init ? src_v : there_q;
	assign par_wd = cmd.bfs_init ? src_v : here_q;
	assign que_we = cmd.bfs_init || hit;
	assign que_wa = cmd.bfs_init ? '0 : tail_q[VW-1:0];
	assign que_wd = cmd.bfs_init ? src_v : there_q;

	always_ff @(posedge clk) begin
		if (cap_we) cap_mem[cap_wa] <= cap_wd;
		if (cap_re) cap_rd_q <= cap_mem[cap_ra];
	end

	always_ff @(posedge clk) begin
		if (flow_we) flow_mem[flow_wa] <= flow_wd;
		if (flow_re) flow_rd_q <= flow_mem[flow_ra];
	end

	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_wa] <= par_wd;
		if (cmd.prd) par_rd_q <= par_mem[p_q];
	end

	always_ff @(posedge clk) begin
		if (que_we) que_mem[que_wa] <= que_wd;
		if (cmd.pop_rd) que_rd_q <= que_mem[head_q[VW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= mfek_pkg::VC_RESET;
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			visited_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) vc_q <= vertex_count;
			if (cmd.clr_cap || cmd.clr_flow) clr_q <= clr_q + AW'(1);
			if (cmd.bfs_init) begin
				head_q    <= '0;
				tail_q    <= NW'(1);
				visited_q <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << src_v;
			end else begin
				if (cmd.pop_rd) head_q <= head_q + NW'(1);
				if (hit) begin
					tail_q             <= tail_q + NW'(1);
					visited_q[there_q] <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q   <= mfek_pkg::req_t'(req_type);
			a_q     <= vertex_a;
			b_q     <= vertex_b;
			ec_q    <= edge_capacity;
			total_q <= '0;
		end
		if (cmd.pop_take) begin
			here_q  <= que_rd_q;
			there_q <= '0;
		end
		if (cmd.scan_chk) there_q <= there_q + VW'(1);
		if (cmd.found) begin
			amount_q <= '1;
			p_q      <= snk_v;
		end
		if (cmd.w2_start) p_q <= snk_v;
		if (cmd.w1_q || cmd.w2_q) q_q <= par_rd_q;
		if (cmd.w1_min) begin
			if (resid < $signed({2'b00, amount_q})) amount_q <= resid[CW-1:0];
			p_q <= q_q;
		end
		if (cmd.w2_bwd) p_q <= q_q;
		if (cmd.add_total) total_q <= total_q + TW'(amount_q);
		if (cmd.load_out) begin
			value_q <= value_d;
			bad_q   <= (req_q == mfek_pkg::REQ_COMPUTE) && (a_q == b_q);
		end
	end

	assign flow_ext  = {{23{flow_rd_q[FW-1]}}, flow_rd_q};
	assign total_sat = (SW'(total_q) > SW'(mfek_pkg::VALUE_POS_MAX))
		? 23'(mfek_pkg::VALUE_POS_MAX) : 23'(total_q);

	always_comb begin
		if (req_q == mfek_pkg::REQ_QUERY) begin
			value_d = range_ok ? $signed(flow_ext[22:0]) : '0;
		end else if (a_q == b_q) begin
			value_d = '0;
		end else begin
			value_d = $signed(total_sat);
		end
	end

	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign bad_request = bad_q;

	assign sts.kind      = req_q;
	assign sts.same_ab   = (a_q == b_q);
	assign sts.range_ok  = range_ok;
	assign sts.clr_done  = (clr_q == '1);
	assign sts.pop_more  = (head_q < tail_q);
	assign sts.scan_last = ((NW'(there_q) + NW'(1)) == n_act);
	assign sts.snk_found = visited_q[snk_v];
	assign sts.p_is_src  = (p_q == src_v);
	assign sts.out_free  = out_free;

	`MFEK_ASSERT_NOW(a_head_le_tail, clk, arst_n, 1'b1, head_q <= tail_q)
	`MFEK_ASSERT_NOW(a_tail_bound, clk, arst_n, 1'b1, tail_q <= NW'(MAX_VERTICES))
	`MFEK_ASSERT_NOW(a_load_free, clk, arst_n, cmd.load_out, !out_valid_q || !out_stall)
	`MFEK_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.load_out, out_valid_q)

endmodule

`default_nettype wire

// File: sv/max_flow_edmonds_karp.sv
// ----------------------------------------------------------------------------
// Max flow, Edmonds-Karp
// Requests on the input channel: clear capacities, set edge capacity, compute
// the maximum flow from vertex_a to vertex_b, query the flow of edge a to b.
// Compute and query give one result on the output channel; clear and set none.
// The vertex count register is written on its own channel, always ready.
// Clear sweeps the capacity memory, MAX_VERTICES rounded up to a power of two,
// squared, entries (4096 at defaults). Compute sweeps the flow memory the same
// way, then repeats a breadth-first search and an augmentation along the path
// found until the sink is no longer reached.
// After reset the block sweeps both memories with in_stall high. A stalled
// result is held; the next request is still taken while it waits, but its own
// result waits until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module max_flow_edmonds_karp #(
	parameter int MAX_VERTICES   = 64,
	parameter int CAPACITY_WIDTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [6:0]    vertex_count,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    req_type,
	input  wire logic [5:0]    vertex_a,
	input  wire logic [5:0]    vertex_b,
	input  wire logic [15:0]   edge_capacity,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic signed [22:0] value,
	output logic               bad_request
);

	mfek_pkg::cmd_t cmd;
	mfek_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	mfek_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mfek_dp #(
		.MAX_VERTICES   (MAX_VERTICES),
		.CAPACITY_WIDTH (CAPACITY_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.vertex_count  (vertex_count),
		.req_type      (req_type),
		.vertex_a      (vertex_a),
		.vertex_b      (vertex_b),
		.edge_capacity (edge_capacity),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.value         (value),
		.bad_request   (bad_request),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

`default_nettype wire
